// ===== sv/ffha_pkg.sv =====
// Package for the first-fit heap allocator.
// Holds the item types, status and command codes, and the block table entry type.
// No dependencies.
package ffha_pkg;

  // Address width of the heap; fixed by the item fields.
  localparam int ADDR_BITS = 16;
  // Width of the heap limit register.
  localparam int LIMIT_BITS = 17;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'h10000;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCKS_DEF = 32;
  localparam int HEADER_BYTES_DEF = 40;

  // Width of the table index carried in a command; covers up to 511 blocks.
  localparam int CMD_IDX_BITS = 9;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic opcode;
    logic [15:0] req_size;
    logic [ADDR_BITS-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [ADDR_BITS-1:0] data_addr;
  } resp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic free;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_NOP = 3'd0,
    CMD_SCAN = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_ABSORB = 3'd4,
    CMD_SET = 3'd5
  } cmd_kind_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cmd_kind_t kind;
    logic [CMD_IDX_BITS-1:0] k;
    logic [CMD_IDX_BITS-1:0] count;
    logic op_free;
    logic [ADDR_BITS:0] tam;
    logic [ADDR_BITS-1:0] addr;
    entry_t wr;
    logic set_size;
  } cmd_t;

  // Data gathered from the selected cell and its two neighbors.
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [ADDR_BITS-1:0] lstart;
    logic lfree;
    logic rfree;
  } gather_t;

endpackage

// ===== sv/ffha_cell.sv =====
// One block table cell of the first-fit heap allocator.
// Holds one table entry, shifts with its neighbors and takes part in the first-hit chain.
// Depends on ffha_pkg.
module ffha_cell #(
  parameter int IDX = 0,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  ffha_pkg::cmd_t cmd,
  input  ffha_pkg::entry_t left_ent,
  input  ffha_pkg::entry_t right_ent,
  input  logic found_in,
  output logic found_out,
  input  logic sel_left,
  input  logic sel_right,
  output logic sel,
  output ffha_pkg::entry_t ent,
  output ffha_pkg::gather_t gath
);

  localparam int A = ffha_pkg::ADDR_BITS;
  localparam int IW = ffha_pkg::CMD_IDX_BITS;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [A:0] HDR_W = (A + 1)'(HEADER_BYTES);

  logic valid;
  logic match;
  logic fit;
  logic hit;

  assign valid = MY_IDX < cmd.count;
  assign match = ({1'b0, ent.start} + HDR_W) == {1'b0, cmd.addr};
  assign fit = ent.free && ({1'b0, ent.size} >= cmd.tam);
  assign hit = valid && (cmd.op_free ? match : fit);
  assign found_out = found_in | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (cmd.kind == ffha_pkg::CMD_SCAN) begin
      sel <= hit & ~found_in;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.kind)
      ffha_pkg::CMD_INSERT: begin
        if (MY_IDX > cmd.k) begin
          ent <= left_ent;
        end else if (MY_IDX == cmd.k) begin
          ent <= cmd.wr;
        end
      end
      ffha_pkg::CMD_REMOVE: begin
        if (MY_IDX >= cmd.k) begin
          ent <= right_ent;
        end
      end
      ffha_pkg::CMD_ABSORB: begin
        if (MY_IDX > cmd.k) begin
          ent <= right_ent;
        end else if (MY_IDX == cmd.k) begin
          ent.size <= ent.size + A'(HEADER_BYTES) + right_ent.size;
        end
      end
      ffha_pkg::CMD_SET: begin
        if (MY_IDX == cmd.k) begin
          ent.free <= cmd.wr.free;
          if (cmd.set_size) begin
            ent.size <= cmd.wr.size;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign gath.start = sel ? ent.start : '0;
  assign gath.size = sel ? ent.size : '0;
  assign gath.lstart = sel_right ? ent.start : '0;
  assign gath.lfree = sel_right & ent.free;
  assign gath.rfree = sel_left & ent.free;

endmodule

// ===== sv/ffha_ctrl.sv =====
// Controller of the first-fit heap allocator.
// Sequences scan, pick and table commands, and holds count, heap top, limit and the result.
// Depends on ffha_pkg.
module ffha_ctrl #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ffha_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ffha_pkg::resp_t out_data,
  input  logic cfg_we,
  input  logic [ffha_pkg::LIMIT_BITS-1:0] cfg_wdata,
  input  logic [MAX_BLOCKS-1:0] sel_vec,
  input  logic found,
  input  ffha_pkg::gather_t gath,
  output ffha_pkg::cmd_t cmd
);

  localparam int A = ffha_pkg::ADDR_BITS;
  localparam int LB = ffha_pkg::LIMIT_BITS;
  localparam int IW = ffha_pkg::CMD_IDX_BITS;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [A:0] HDR_W = (A + 1)'(HEADER_BYTES);
  localparam logic [A:0] SPLIT_MIN = (A + 1)'(HEADER_BYTES + 4);
  localparam logic [LB-1:0] ADDR_CAP = LB'((1 << A) - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_PICK = 7'b0000100,
    S_PLAN = 7'b0001000,
    S_SET = 7'b0010000,
    S_FRIGHT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [A-1:0] top, top_next;
  logic [CW-1:0] k, k_next;
  logic [LB-1:0] heap_limit;
  logic op_free;
  logic [A:0] tam;
  logic [A-1:0] addr;
  logic found_r;
  ffha_pkg::gather_t g;
  ffha_pkg::resp_t resp, resp_next;
  logic last, last_next;
  logic [A-1:0] trim_start, trim_start_next;

  logic [CW-1:0] k_enc;
  logic [LB-1:0] eff_limit;
  logic [A:0] left;
  logic split;
  logic [A+1:0] newtop;
  logic lm;

  always_comb begin
    k_enc = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (sel_vec[i]) begin
        k_enc = k_enc | CW'(i);
      end
    end
  end

  assign eff_limit = (heap_limit < ADDR_CAP) ? heap_limit : ADDR_CAP;
  assign left = {1'b0, g.size} - tam;
  assign split = (left >= SPLIT_MIN) && (count < MAX_CNT);
  assign newtop = {2'b00, top} + {1'b0, HDR_W} + {1'b0, tam};
  assign lm = (k != '0) && g.lfree;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    top_next = top;
    k_next = k;
    resp_next = resp;
    last_next = last;
    trim_start_next = trim_start;
    cmd = '0;
    cmd.kind = ffha_pkg::CMD_NOP;
    cmd.count = IW'(count);
    cmd.op_free = op_free;
    cmd.tam = tam;
    cmd.addr = addr;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.kind = ffha_pkg::CMD_SCAN;
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = S_PLAN;
      end
      S_PLAN: begin
        state_next = S_DONE;
        if (!op_free && found_r) begin
          resp_next.status = ffha_pkg::ST_OK;
          resp_next.data_addr = A'({1'b0, g.start} + HDR_W);
          if (split) begin
            cmd.kind = ffha_pkg::CMD_INSERT;
            cmd.k = IW'(k + ONE);
            cmd.wr.start = A'({1'b0, g.start} + HDR_W + tam);
            cmd.wr.size = A'(left - HDR_W);
            cmd.wr.free = 1'b1;
            count_next = count + ONE;
            state_next = S_SET;
          end else begin
            cmd.kind = ffha_pkg::CMD_SET;
            cmd.k = IW'(k);
            cmd.wr.free = 1'b0;
            cmd.set_size = 1'b0;
          end
        end else if (!op_free) begin
          if ((count >= MAX_CNT) || (newtop > {1'b0, eff_limit})) begin
            resp_next.status = ffha_pkg::ST_NO_SPACE;
            resp_next.data_addr = '0;
          end else begin
            cmd.kind = ffha_pkg::CMD_INSERT;
            cmd.k = IW'(count);
            cmd.wr.start = top;
            cmd.wr.size = A'(tam);
            cmd.wr.free = 1'b0;
            count_next = count + ONE;
            top_next = A'(newtop);
            resp_next.status = ffha_pkg::ST_OK;
            resp_next.data_addr = A'({1'b0, top} + HDR_W);
          end
        end else if (!found_r) begin
          resp_next.status = ffha_pkg::ST_BAD_ADDR;
          resp_next.data_addr = '0;
        end else begin
          resp_next.status = ffha_pkg::ST_OK;
          resp_next.data_addr = '0;
          last_next = (k + ONE) == count;
          state_next = S_FRIGHT;
          if (lm) begin
            // The left neighbor is free: it swallows this block.
            cmd.kind = ffha_pkg::CMD_ABSORB;
            cmd.k = IW'(k - ONE);
            count_next = count - ONE;
            k_next = k - ONE;
            trim_start_next = g.lstart;
          end else begin
            cmd.kind = ffha_pkg::CMD_SET;
            cmd.k = IW'(k);
            cmd.wr.free = 1'b1;
            cmd.set_size = 1'b0;
            trim_start_next = g.start;
          end
        end
      end
      S_SET: begin
        cmd.kind = ffha_pkg::CMD_SET;
        cmd.k = IW'(k);
        cmd.wr.size = A'(tam);
        cmd.wr.free = 1'b0;
        cmd.set_size = 1'b1;
        state_next = S_DONE;
      end
      S_FRIGHT: begin
        state_next = S_DONE;
        if (!last && g.rfree) begin
          cmd.kind = ffha_pkg::CMD_ABSORB;
          cmd.k = IW'(k);
          count_next = count - ONE;
        end else if (last && (k != '0)) begin
          // A free block at the end of the heap is trimmed off, unless it is the only block.
          cmd.kind = ffha_pkg::CMD_REMOVE;
          cmd.k = IW'(k);
          count_next = count - ONE;
          top_next = trim_start;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      top <= '0;
      heap_limit <= ffha_pkg::LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      top <= top_next;
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      op_free <= (in_data.opcode == ffha_pkg::OP_FREE);
      tam <= ({1'b0, in_data.req_size} + (A + 1)'(3)) & ~((A + 1)'(3));
      addr <= in_data.free_addr;
    end
    if (state == S_SCAN) begin
      found_r <= found;
    end
    if (state == S_PICK) begin
      k <= k_enc;
      g <= gath;
    end else begin
      k <= k_next;
    end
    resp <= resp_next;
    last <= last_next;
    trim_start <= trim_start_next;
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_data <= resp;
    end
  end

endmodule

// ===== sv/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator.
// Builds the row of table cells and the controller; depends on ffha_pkg, ffha_cell, ffha_ctrl.
//
//   Channel  Direction  Handshake                   Payload
//   in       input      in_valid / in_ready         in_data  (ffha_pkg::req_t)
//   out      output     out_valid / out_ready       out_data (ffha_pkg::resp_t)
//   cfg      input      cfg_we (no wait)            cfg_wdata (heap limit)
//
// An accepted item passes the scan, pick and plan states, plus a set state when
// an allocation splits a block or a free-right state when a free finds its block,
// then done, where the result is loaded; the controller issues at most one table
// command per cycle. The block goes back to idle as the result is loaded and
// takes the next item in the cycle after, so no item is taken while one is in flight.
// Reset is synchronous on rst and clears the block count, the heap top and
// the limit (to 65536); the table entries themselves are not cleared.
// A result held by a stalled out channel delays the return to idle until taken.
module first_fit_heap_allocator_top #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ffha_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ffha_pkg::resp_t out_data,
  input  logic cfg_we,
  input  logic [ffha_pkg::LIMIT_BITS-1:0] cfg_wdata
);

  // Table entries, one per cell, and the first-hit chain between cells.
  ffha_pkg::entry_t ent [MAX_BLOCKS];
  ffha_pkg::gather_t gath [MAX_BLOCKS];
  logic [MAX_BLOCKS:0] found_chain;
  logic [MAX_BLOCKS-1:0] sel_vec;
  ffha_pkg::gather_t gath_all;
  ffha_pkg::cmd_t cmd;

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffha_pkg::entry_t left_ent;
    ffha_pkg::entry_t right_ent;
    logic sel_left;
    logic sel_right;

    // The row ends see empty neighbors; the last cell shifts the zero entry in on a remove or absorb.
    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign sel_left = 1'b0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
      assign sel_left = sel_vec[i-1];
    end
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign right_ent = '0;
      assign sel_right = 1'b0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
      assign sel_right = sel_vec[i+1];
    end

    ffha_cell #(
      .IDX(i),
      .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cmd(cmd),
      .left_ent(left_ent),
      .right_ent(right_ent),
      .found_in(found_chain[i]),
      .found_out(found_chain[i+1]),
      .sel_left(sel_left),
      .sel_right(sel_right),
      .sel(sel_vec[i]),
      .ent(ent[i]),
      .gath(gath[i])
    );
  end

  // At most one cell is selected, so its data and its neighbors' flags are
  // collected with a plain OR across the row.
  always_comb begin
    gath_all = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      gath_all = gath_all | gath[i];
    end
  end

  ffha_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .sel_vec(sel_vec),
    .found(found_chain[MAX_BLOCKS]),
    .gath(gath_all),
    .cmd(cmd)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for first_fit_heap_allocator_top: allocate/free items go in,
// a scoreboard keeps a block-table model and checks every status and data address.
// Depends on ffha_pkg and the allocator RTL only.
module tb_top;

  localparam int HDR = ffha_pkg::HEADER_BYTES_DEF;
  localparam int NBLK = ffha_pkg::MAX_BLOCKS_DEF;
  // Cycles the block is given to settle before touching the limit register or
  // ending the run.
  localparam int SETTLE_CYCLES = 10;
  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;

  // Block-table model plus the queue of results still owed by the block.
  class heap_scoreboard;
    logic [15:0] blk_start [NBLK];
    logic [15:0] blk_size [NBLK];
    bit blk_free [NBLK];
    int blk_count;
    logic [16:0] heap_top;
    logic [16:0] heap_limit;
    ffha_pkg::resp_t pending_q[$];
    int mismatches;
    int checked;
    int n_alloc_ok, n_no_space, n_bad_free, n_free_ok;
    int n_split, n_split_held, n_trim, n_full_refusal, peak_count;

    function new();
      blk_count = 0;
      heap_top = '0;
      heap_limit = ffha_pkg::LIMIT_RESET;
      mismatches = 0;
      checked = 0;
      n_alloc_ok = 0; n_no_space = 0; n_bad_free = 0; n_free_ok = 0;
      n_split = 0; n_split_held = 0; n_trim = 0; n_full_refusal = 0;
      peak_count = 0;
    endfunction

    function void set_limit(logic [16:0] v);
      heap_limit = v;
    endfunction

    function void remove_at(int k);
      for (int j = k; j + 1 < blk_count; j++) begin
        blk_start[j] = blk_start[j + 1];
        blk_size[j] = blk_size[j + 1];
        blk_free[j] = blk_free[j + 1];
      end
      blk_count--;
    endfunction

    function void insert_at(int k, logic [15:0] s, logic [15:0] z, bit f);
      for (int j = blk_count; j > k; j--) begin
        blk_start[j] = blk_start[j - 1];
        blk_size[j] = blk_size[j - 1];
        blk_free[j] = blk_free[j - 1];
      end
      blk_start[k] = s;
      blk_size[k] = z;
      blk_free[k] = f;
      blk_count++;
      if (blk_count > peak_count) peak_count = blk_count;
    endfunction

    // Fold block k+1 into block k, header included.
    function void absorb_right(int k);
      blk_size[k] = 16'(int'(blk_size[k]) + HDR + int'(blk_size[k + 1]));
      remove_at(k + 1);
    endfunction

    function ffha_pkg::resp_t predict_alloc(logic [15:0] req);
      logic [16:0] tam;
      int leftover;
      int newtop;
      int cap;
      ffha_pkg::resp_t r;
      tam = ({1'b0, req} + 17'd3) & 17'h1FFFC;
      r.status = ffha_pkg::ST_OK;
      r.data_addr = '0;
      // First fit in address order.
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && {1'b0, blk_size[i]} >= tam) begin
          leftover = int'(blk_size[i]) - int'(tam);
          if (leftover >= HDR + 4) begin
            if (blk_count < NBLK) begin
              insert_at(i + 1, 16'(int'(blk_start[i]) + HDR + int'(tam)),
                        16'(leftover - HDR), 1'b1);
              blk_size[i] = tam[15:0];
              n_split++;
            end else begin
              n_split_held++;
            end
          end
          blk_free[i] = 1'b0;
          r.data_addr = 16'(int'(blk_start[i]) + HDR);
          n_alloc_ok++;
          return r;
        end
      end
      // Nothing fits, so try to grow the heap at its top.
      newtop = int'(heap_top) + HDR + int'(tam);
      cap = (heap_limit < 17'd65535) ? int'(heap_limit) : 65535;
      if (blk_count >= NBLK || newtop > cap) begin
        if (blk_count >= NBLK) n_full_refusal++;
        n_no_space++;
        r.status = ffha_pkg::ST_NO_SPACE;
        return r;
      end
      insert_at(blk_count, heap_top[15:0], tam[15:0], 1'b0);
      r.data_addr = 16'(int'(heap_top) + HDR);
      heap_top = 17'(newtop);
      n_alloc_ok++;
      return r;
    endfunction

    function ffha_pkg::resp_t predict_free(logic [15:0] addr);
      int idx;
      ffha_pkg::resp_t r;
      idx = -1;
      r.status = ffha_pkg::ST_OK;
      r.data_addr = '0;
      for (int i = 0; i < blk_count; i++) begin
        if (int'(blk_start[i]) + HDR == int'(addr)) begin
          idx = i;
          break;
        end
      end
      if (idx < 0) begin
        n_bad_free++;
        r.status = ffha_pkg::ST_BAD_ADDR;
        return r;
      end
      n_free_ok++;
      blk_free[idx] = 1'b1;
      if (idx > 0 && blk_free[idx - 1]) begin
        absorb_right(idx - 1);
        idx--;
      end
      if (idx + 1 < blk_count) begin
        if (blk_free[idx + 1]) absorb_right(idx);
      end else if (idx > 0) begin
        // Free block at the end of the heap gives its space back to the top.
        heap_top = {1'b0, blk_start[idx]};
        remove_at(idx);
        n_trim++;
      end
      return r;
    endfunction

    function void note_input(ffha_pkg::req_t item);
      if (item.opcode == ffha_pkg::OP_ALLOC) pending_q.push_back(predict_alloc(item.req_size));
      else pending_q.push_back(predict_free(item.free_addr));
    endfunction

    function void check_result(ffha_pkg::resp_t got);
      ffha_pkg::resp_t exp_r;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: unexpected result %0d: status %0d addr %0d",
                   checked, got.status, got.data_addr);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status || got.data_addr !== exp_r.data_addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"tb_top: result %0d wrong: expected status %0d addr %0d,",
                    " got status %0d addr %0d"},
                   checked, exp_r.status, exp_r.data_addr, got.status, got.data_addr);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffha_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffha_pkg::resp_t out_data;
  logic cfg_we = 1'b0;
  logic [ffha_pkg::LIMIT_BITS-1:0] cfg_wdata = '0;

  heap_scoreboard sb;
  int items_sent = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int mode_timer = 0;

  always #4 clk = ~clk;

  first_fit_heap_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // The result side checks each accepted result, then picks the next ready
  // level. The stall pattern switches between several shapes every so often:
  // always ready, coin toss, mostly stalled, and a fixed one-in-three stall.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (mode_timer == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_timer <= $urandom_range(16, 200);
    end else begin
      mode_timer <= mode_timer - 1;
    end
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        out_ready <= (mode_timer % 3 != 0);
      end
    endcase
  end

  // Watchdog: a healthy block moves an item on one channel or the other well
  // within this many cycles, even under the heaviest stall pattern.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles, %0d items sent, %0d results pending",
               idle_cycles, items_sent, sb.pending_q.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ffha_pkg::req_t alloc_req(logic [15:0] size);
    ffha_pkg::req_t r;
    r.opcode = ffha_pkg::OP_ALLOC;
    r.req_size = size;
    r.free_addr = 16'($urandom);
    return r;
  endfunction

  function automatic ffha_pkg::req_t free_req(logic [15:0] addr);
    ffha_pkg::req_t r;
    r.opcode = ffha_pkg::OP_FREE;
    r.req_size = 16'($urandom);
    r.free_addr = addr;
    return r;
  endfunction

  // Hold the item on the channel until the block takes it, then let the
  // scoreboard predict its result. Called and returning at a rising edge.
  task automatic send_item(input ffha_pkg::req_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
    items_sent++;
  endtask

  // Stop sending, let every owed result come back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ffha_pkg::LIMIT_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Most frees name a live table entry (free ones too, which makes double
  // frees); the rest are near misses or arbitrary addresses. Sizes stay mostly
  // under size_max so the table fills up, with a few large and raw requests.
  function automatic ffha_pkg::req_t random_item(int alloc_pct, int size_max);
    int k;
    logic [15:0] base;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      if (k < 90) return alloc_req(16'($urandom_range(0, size_max)));
      if (k < 97) return alloc_req(16'($urandom_range(0, 20000)));
      return alloc_req(16'($urandom));
    end
    if (sb.blk_count > 0 && k < 92) begin
      base = 16'(int'(sb.blk_start[$urandom_range(0, sb.blk_count - 1)]) + HDR);
      if (k < 84) return free_req(base);
      return free_req(($urandom_range(0, 1) == 1) ? base + 16'd4 : base - 16'd4);
    end
    return free_req(16'($urandom));
  endfunction

  // Items go out in bursts of random length; between bursts the channel idles
  // for a random gap, and about a third of the time there is no gap at all.
  task automatic run_random(input int n_items, input int alloc_pct, input int size_max);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      send_item(random_item(alloc_pct, size_max));
      burst_left--;
    end
  endtask

  // Hand-picked opening sequence at the reset limit. Addresses follow from
  // the 40-byte header: blocks start at 0, 40, 84 after the first three grows.
  task automatic run_directed();
    send_item(free_req(16'd40));      // free while the table is empty
    send_item(alloc_req(16'd0));      // zero-size block at 0, data at 40
    send_item(alloc_req(16'd1));      // rounds up to 4, data at 80
    send_item(alloc_req(16'hFFFF));   // far past the limit: no space
    send_item(alloc_req(16'd100));    // data at 124, top now 224
    send_item(free_req(16'd81));      // off by one: no such block
    send_item(free_req(16'd80));      // plain free, both neighbors busy
    send_item(free_req(16'd80));      // double free is accepted
    send_item(free_req(16'd124));     // merges left, then trims the heap end
    send_item(free_req(16'd40));      // only block stays as a free block
    send_item(alloc_req(16'd0));      // reuses the free zero-size block
    send_item(alloc_req(16'd200));    // grows: block at 40
    send_item(alloc_req(16'd8));      // grows: block at 280
    send_item(alloc_req(16'd16));     // grows: block at 328
    send_item(free_req(16'd80));      // frees the 200-byte block
    send_item(alloc_req(16'd12));     // first fit splits it
    send_item(alloc_req(16'd104));    // leftover exactly header plus 4: splits
    send_item(alloc_req(16'd4));      // exact fit, no split
    send_item(free_req(16'd320));     // free between two busy blocks
    send_item(free_req(16'd276));     // merges with its free right neighbor
    send_item(free_req(16'd368));     // merges left and trims the end
    send_item(free_req(16'hFFFF));    // all-ones address: no such block
    send_item(alloc_req(16'hFFFC));   // largest multiple of 4: no space
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Allocation-heavy with tiny sizes so the table fills to its last entry;
    // that is where a split is held back and growth is refused.
    write_limit(17'h10000);
    run_random(300, 85, 64);
    // No room to grow at all: only reuse of freed blocks can succeed.
    write_limit(17'h00000);
    run_random(150, 50, 200);
    // Top register value; the address width caps the heap instead.
    write_limit(17'h1FFFF);
    run_random(300, 60, 2000);
    write_limit(17'd2000);
    run_random(200, 60, 300);
    write_limit(17'd65535);
    run_random(220, 50, 400);
    write_limit(17'($urandom_range(0, 131071)));
    run_random(200, 55, 1000);

    drain();

    $display("tb_top: %0d items, %0d results; %0d allocs ok, %0d no space (%0d full table)",
             items_sent, sb.checked, sb.n_alloc_ok, sb.n_no_space, sb.n_full_refusal);
    $display({"tb_top: %0d frees ok, %0d bad frees, %0d splits, %0d held splits,",
              " %0d trims, peak %0d blocks"},
             sb.n_free_ok, sb.n_bad_free, sb.n_split, sb.n_split_held, sb.n_trim,
             sb.peak_count);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches, %0d results never seen", sb.mismatches,
               sb.pending_q.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ffha_pkg.sv
sv/ffha_cell.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator_top.sv
dv/tb_top.sv
